// ===== rtl/ybs_pkg.sv =====
package ybs_pkg;

  // fixed point widths: products of 9-bit signed luma and 8-bit signed chroma samples by Q10 weights
  localparam int PROD_W = 21;
  localparam int SUM_W  = 22;
  localparam int Q_SHIFT = 10;

  // Q10 coefficients
  localparam logic signed [PROD_W-1:0] K_LUMA     = PROD_W'(1192);
  localparam logic signed [PROD_W-1:0] K_RED_C2   = PROD_W'(2066);
  localparam logic signed [PROD_W-1:0] K_GREEN_C1 = PROD_W'(833);
  localparam logic signed [PROD_W-1:0] K_GREEN_C2 = PROD_W'(400);
  localparam logic signed [PROD_W-1:0] K_BLUE_C1  = PROD_W'(1634);

  localparam logic signed [8:0] LUMA_OFFSET = 9'sd16;
  localparam logic [7:0] CHROMA_FLIP = 8'h80;

  // one packed yuyv group
  typedef struct packed {
    logic [7:0] luma_0;
    logic [7:0] chroma_first;
    logic [7:0] luma_1;
    logic [7:0] chroma_second;
    logic       last_in_frame;
  } ybs_group_t;

  // weighted terms after the multiplier stage
  typedef struct packed {
    logic signed [PROD_W-1:0] luma_0;
    logic signed [PROD_W-1:0] luma_1;
    logic signed [PROD_W-1:0] red_c2;
    logic signed [PROD_W-1:0] green_c1;
    logic signed [PROD_W-1:0] green_c2;
    logic signed [PROD_W-1:0] blue_c1;
    logic                     last;
  } ybs_prod_t;

  // channel sums before clamping
  typedef struct packed {
    logic signed [SUM_W-1:0] blue_0;
    logic signed [SUM_W-1:0] green_0;
    logic signed [SUM_W-1:0] red_0;
    logic signed [SUM_W-1:0] blue_1;
    logic signed [SUM_W-1:0] green_1;
    logic signed [SUM_W-1:0] red_1;
    logic                    last;
  } ybs_sum_t;

  // two bgr pixels
  typedef struct packed {
    logic [7:0] blue_0;
    logic [7:0] green_0;
    logic [7:0] red_0;
    logic [7:0] blue_1;
    logic [7:0] green_1;
    logic [7:0] red_1;
    logic       frame_end;
  } ybs_bgr_t;

endpackage

// ===== rtl/ybs_if.sv =====
// input channel: one yuyv group per request
interface ybs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_0;
  logic [7:0] chroma_first;
  logic [7:0] luma_1;
  logic [7:0] chroma_second;
  logic       last_in_frame;

  modport source (
    output valid, luma_0, chroma_first, luma_1, chroma_second, last_in_frame,
    input  ready
  );
  modport sink (
    input  valid, luma_0, chroma_first, luma_1, chroma_second, last_in_frame,
    output ready
  );
endinterface

// result channel: two bgr pixels per request
interface ybs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_0;
  logic [7:0] green_0;
  logic [7:0] red_0;
  logic [7:0] blue_1;
  logic [7:0] green_1;
  logic [7:0] red_1;
  logic       frame_end;

  modport source (
    output valid, blue_0, green_0, red_0, blue_1, green_1, red_1, frame_end,
    input  ready
  );
  modport sink (
    input  valid, blue_0, green_0, red_0, blue_1, green_1, red_1, frame_end,
    output ready
  );
endinterface

// ===== rtl/yuyv_to_bgr_stream_unit.sv =====
// Converts packed YUYV groups (two luma bytes sharing one chroma pair) into two
// BGR pixels each, using Q10 coefficients 1192/2066/833/400/1634 with luma offset
// 16 and chroma offset 128, floor by 1024 and clamp to 0..255; the frame-end flag
// rides along. One group is accepted every clock while the output is not stalled; the multiplier,
// adder and clamp register stages lie between input request and result.
// A stalled output holds its result and back-pressure reaches the input only once
// all three stages are full. Reset clears the stage valid bits only.
module yuyv_to_bgr_stream_unit (
  input logic       clk,
  input logic       rst_n,
  ybs_in_if.sink    in_ch,
  ybs_out_if.source out_ch
);

  ybs_pkg::ybs_group_t in_data;
  ybs_pkg::ybs_prod_t  prod_data;
  ybs_pkg::ybs_sum_t   sum_data;
  ybs_pkg::ybs_bgr_t   bgr_data;

  logic prod_valid;
  logic prod_ready;
  logic sum_valid;
  logic sum_ready;

  // input payload
  always_comb begin
    in_data.luma_0        = in_ch.luma_0;
    in_data.chroma_first  = in_ch.chroma_first;
    in_data.luma_1        = in_ch.luma_1;
    in_data.chroma_second = in_ch.chroma_second;
    in_data.last_in_frame = in_ch.last_in_frame;
  end

  ybs_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  ybs_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  ybs_clamp u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (bgr_data)
  );

  // result payload
  always_comb begin
    out_ch.blue_0    = bgr_data.blue_0;
    out_ch.green_0   = bgr_data.green_0;
    out_ch.red_0     = bgr_data.red_0;
    out_ch.blue_1    = bgr_data.blue_1;
    out_ch.green_1   = bgr_data.green_1;
    out_ch.red_1     = bgr_data.red_1;
    out_ch.frame_end = bgr_data.frame_end;
  end

  // ready sink means every stage can advance
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output sink is ready");

  // input back-pressure only with every stage register full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && prod_valid && sum_valid))
    else $error("input stalled with a bubble in the pipeline");

  // a stalled middle stage holds its request
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_valid && !sum_ready) |=> (sum_valid && $stable(sum_data)))
    else $error("sum stage changed while stalled");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/ybs_mult.sv =====
module ybs_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  ybs_pkg::ybs_group_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output ybs_pkg::ybs_prod_t  dn_data
);

  logic               vld_r;
  ybs_pkg::ybs_prod_t data_r;
  ybs_pkg::ybs_prod_t data_nxt;

  logic signed [8:0] y0;
  logic signed [8:0] y1;
  logic signed [7:0] c1;
  logic signed [7:0] c2;

  // remove offsets: chroma offset of 128 is a flip of the top bit
  always_comb begin
    y0 = $signed({1'b0, up_data.luma_0}) - ybs_pkg::LUMA_OFFSET;
    y1 = $signed({1'b0, up_data.luma_1}) - ybs_pkg::LUMA_OFFSET;
    c1 = $signed(up_data.chroma_first ^ ybs_pkg::CHROMA_FLIP);
    c2 = $signed(up_data.chroma_second ^ ybs_pkg::CHROMA_FLIP);
  end

  // constant weight products
  always_comb begin
    data_nxt.luma_0   = ybs_pkg::PROD_W'(y0) * ybs_pkg::K_LUMA;
    data_nxt.luma_1   = ybs_pkg::PROD_W'(y1) * ybs_pkg::K_LUMA;
    data_nxt.red_c2   = ybs_pkg::PROD_W'(c2) * ybs_pkg::K_RED_C2;
    data_nxt.green_c1 = ybs_pkg::PROD_W'(c1) * ybs_pkg::K_GREEN_C1;
    data_nxt.green_c2 = ybs_pkg::PROD_W'(c2) * ybs_pkg::K_GREEN_C2;
    data_nxt.blue_c1  = ybs_pkg::PROD_W'(c1) * ybs_pkg::K_BLUE_C1;
    data_nxt.last     = up_data.last_in_frame;
  end

  assign up_ready = !vld_r || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/ybs_sum.sv =====
module ybs_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ybs_pkg::ybs_prod_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ybs_pkg::ybs_sum_t  dn_data
);

  logic              vld_r;
  ybs_pkg::ybs_sum_t data_r;
  ybs_pkg::ybs_sum_t data_nxt;

  logic signed [ybs_pkg::SUM_W-1:0] ly0;
  logic signed [ybs_pkg::SUM_W-1:0] ly1;
  logic signed [ybs_pkg::SUM_W-1:0] red_t;
  logic signed [ybs_pkg::SUM_W-1:0] green_t;
  logic signed [ybs_pkg::SUM_W-1:0] blue_t;

  // shared chroma terms, then one add per channel and pixel
  always_comb begin
    ly0     = ybs_pkg::SUM_W'(up_data.luma_0);
    ly1     = ybs_pkg::SUM_W'(up_data.luma_1);
    red_t   = ybs_pkg::SUM_W'(up_data.red_c2);
    green_t = -ybs_pkg::SUM_W'(up_data.green_c1) - ybs_pkg::SUM_W'(up_data.green_c2);
    blue_t  = ybs_pkg::SUM_W'(up_data.blue_c1);

    data_nxt.blue_0  = ly0 + blue_t;
    data_nxt.green_0 = ly0 + green_t;
    data_nxt.red_0   = ly0 + red_t;
    data_nxt.blue_1  = ly1 + blue_t;
    data_nxt.green_1 = ly1 + green_t;
    data_nxt.red_1   = ly1 + red_t;
    data_nxt.last    = up_data.last;
  end

  assign up_ready = !vld_r || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/ybs_clamp.sv =====
module ybs_clamp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  ybs_pkg::ybs_sum_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ybs_pkg::ybs_bgr_t dn_data
);

  logic              vld_r;
  ybs_pkg::ybs_bgr_t data_r;
  ybs_pkg::ybs_bgr_t data_nxt;

  // floor by 1024 and saturate to 0..255
  function automatic logic [7:0] sat_channel(input logic signed [ybs_pkg::SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[ybs_pkg::SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[ybs_pkg::SUM_W-2:ybs_pkg::Q_SHIFT+8]) begin
      res = 8'hFF;
    end else begin
      res = sum[ybs_pkg::Q_SHIFT+7:ybs_pkg::Q_SHIFT];
    end
    return res;
  endfunction

  always_comb begin
    data_nxt.blue_0    = sat_channel(up_data.blue_0);
    data_nxt.green_0   = sat_channel(up_data.green_0);
    data_nxt.red_0     = sat_channel(up_data.red_0);
    data_nxt.blue_1    = sat_channel(up_data.blue_1);
    data_nxt.green_1   = sat_channel(up_data.green_1);
    data_nxt.red_1     = sat_channel(up_data.red_1);
    data_nxt.frame_end = up_data.last;
  end

  assign up_ready = !vld_r || dn_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== dv/ybs_bgr_checker.sv =====
`timescale 1ns / 100ps

module ybs_bgr_checker (
  input  logic clk,
  input  logic rst_n,
  ybs_in_if    in_ch,
  ybs_out_if   out_ch,
  output int   mismatch_cnt,
  output int   pixels_owed
);

  // q10 weights, luma scale and the chroma terms per channel
  localparam int W_LUMA     = 1192;
  localparam int W_RED_CR   = 2066;
  localparam int W_GREEN_CB = 833;
  localparam int W_GREEN_CR = 400;
  localparam int W_BLUE_CB  = 1634;
  localparam int LUMA_BIAS   = 16;
  localparam int CHROMA_BIAS = 128;
  localparam int FRAC_BITS   = 10;

  ybs_pkg::ybs_bgr_t pixels_due[$];
  int                errs = 0;

  // negative sums go to zero, then floor and saturate
  function automatic logic [7:0] clamp_q10(input int acc);
    int whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> FRAC_BITS;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  function automatic void shade_pixel(input logic [7:0] luma, input int cb, input int cr,
                                      output logic [7:0] b, output logic [7:0] g,
                                      output logic [7:0] r);
    int luma_w;
    luma_w = W_LUMA * (int'(luma) - LUMA_BIAS);
    r = clamp_q10(luma_w + W_RED_CR * cr);
    g = clamp_q10(luma_w - W_GREEN_CB * cb - W_GREEN_CR * cr);
    b = clamp_q10(luma_w + W_BLUE_CB * cb);
  endfunction

  // both pixels share the chroma pair of the group
  function automatic ybs_pkg::ybs_bgr_t convert_group(input ybs_pkg::ybs_group_t grp);
    ybs_pkg::ybs_bgr_t px;
    int                cb;
    int                cr;
    cb = int'(grp.chroma_first) - CHROMA_BIAS;
    cr = int'(grp.chroma_second) - CHROMA_BIAS;
    shade_pixel(grp.luma_0, cb, cr, px.blue_0, px.green_0, px.red_0);
    shade_pixel(grp.luma_1, cb, cr, px.blue_1, px.green_1, px.red_1);
    px.frame_end = grp.last_in_frame;
    return px;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // results are popped before the new request is pushed
  always @(posedge clk) begin
    ybs_pkg::ybs_bgr_t   want;
    ybs_pkg::ybs_group_t grp;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          errs++;
          $display("%0t: result with none expected, actual bgr %0d/%0d/%0d %0d/%0d/%0d end %0d",
                   $time, out_ch.blue_0, out_ch.green_0, out_ch.red_0,
                   out_ch.blue_1, out_ch.green_1, out_ch.red_1, out_ch.frame_end);
        end else begin
          want = pixels_due.pop_front();
          check_field("blue_0", want.blue_0, out_ch.blue_0);
          check_field("green_0", want.green_0, out_ch.green_0);
          check_field("red_0", want.red_0, out_ch.red_0);
          check_field("blue_1", want.blue_1, out_ch.blue_1);
          check_field("green_1", want.green_1, out_ch.green_1);
          check_field("red_1", want.red_1, out_ch.red_1);
          check_field("frame_end", want.frame_end, out_ch.frame_end);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        grp.luma_0        = in_ch.luma_0;
        grp.chroma_first  = in_ch.chroma_first;
        grp.luma_1        = in_ch.luma_1;
        grp.chroma_second = in_ch.chroma_second;
        grp.last_in_frame = in_ch.last_in_frame;
        pixels_due.push_back(convert_group(grp));
      end
    end
    mismatch_cnt <= errs;
    pixels_owed  <= pixels_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_GROUPS = 450;
  localparam int IDLE_PCT      = 31;
  localparam int TAIL_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  int   mismatch_cnt;
  int   pixels_owed;
  int   quiet_cycles = 0;

  ybs_in_if  in_ch ();
  ybs_out_if out_ch ();

  yuyv_to_bgr_stream_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ybs_bgr_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatch_cnt (mismatch_cnt),
    .pixels_owed  (pixels_owed)
  );

  always #6 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // stop the run when nothing moves on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // bias toward corners of the yuv range
  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [6];
    corner = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd127};
    if ($urandom_range(3) == 0) return corner[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  // random idle cycles, then hold the request until it is taken
  task automatic send_group(input logic [7:0] l0, input logic [7:0] cb, input logic [7:0] l1,
                            input logic [7:0] cr, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.luma_0        <= l0;
    in_ch.chroma_first  <= cb;
    in_ch.luma_1        <= l1;
    in_ch.chroma_second <= cr;
    in_ch.last_in_frame <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pixels_owed != 0);
  endtask

  initial begin
    int frame_left;
    in_ch.valid         <= 1'b0;
    in_ch.luma_0        <= 8'd0;
    in_ch.chroma_first  <= 8'd0;
    in_ch.luma_1        <= 8'd0;
    in_ch.chroma_second <= 8'd0;
    in_ch.last_in_frame <= 1'b0;
    steady              <= 1'b0;
    rst_n               <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners: zero, full scale, black, white, neutral and saturating chroma
    send_group(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_group(8'd16,  8'd128, 8'd16,  8'd128, 1'b0);
    send_group(8'd235, 8'd128, 8'd235, 8'd128, 1'b1);
    send_group(8'd255, 8'd128, 8'd0,   8'd128, 1'b0);
    send_group(8'd0,   8'd128, 8'd255, 8'd128, 1'b1);
    send_group(8'd128, 8'd0,   8'd128, 8'd0,   1'b0);
    send_group(8'd128, 8'd255, 8'd128, 8'd255, 1'b0);
    send_group(8'd128, 8'd0,   8'd128, 8'd255, 1'b1);
    send_group(8'd128, 8'd255, 8'd128, 8'd0,   1'b0);
    send_group(8'd255, 8'd0,   8'd255, 8'd0,   1'b0);
    send_group(8'd0,   8'd255, 8'd0,   8'd255, 1'b1);
    send_group(8'd255, 8'd255, 8'd0,   8'd0,   1'b0);
    send_group(8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
    // saturated color bars and values just around the offsets
    send_group(8'd81,  8'd90,  8'd81,  8'd240, 1'b1);
    send_group(8'd145, 8'd54,  8'd145, 8'd34,  1'b0);
    send_group(8'd41,  8'd240, 8'd41,  8'd110, 1'b0);
    send_group(8'd15,  8'd127, 8'd17,  8'd129, 1'b1);
    send_group(8'd16,  8'd129, 8'd16,  8'd127, 1'b0);
    send_group(8'd255, 8'd0,   8'd255, 8'd255, 1'b1);
    drain_pipe();

    // random frames, with one stretch of no idling and one full drain
    frame_left = $urandom_range(24, 1);
    for (int i = 0; i < RANDOM_GROUPS; i++) begin
      steady <= (i >= 150 && i < 260);
      if (i == 320) drain_pipe();
      send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(), frame_left == 1);
      frame_left--;
      if (frame_left == 0) frame_left = $urandom_range(24, 1);
    end
    steady <= 1'b0;

    // wait out the pipeline, then look for stray results
    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pixels_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
